// File: hdl/crp_pkg.sv
// ---------------------------------------------------------------------------
// crp_pkg: shared types and constants for the response parser
// Character codes, response prefixes, event kinds and the line state record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crp_pkg;

  localparam int FREQ_DIGITS_DEF = 11;
  localparam int FREQ_W          = 37;
  localparam int MODE_W          = 4;
  localparam int LEVEL_W         = 8;
  localparam int LEN_W           = 6;

  localparam logic [7:0] CH_TERM  = 8'h3B;  // ';'
  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam logic [15:0] PFX_FA = 16'h4641;
  localparam logic [15:0] PFX_MD = 16'h4D44;
  localparam logic [15:0] PFX_SM = 16'h534D;
  localparam logic [15:0] PFX_IF = 16'h4946;
  localparam logic [15:0] PFX_AC = 16'h4143;

  localparam logic [LEN_W-1:0] LEN_MAX    = 6'd63;
  localparam logic [LEN_W-1:0] LEN_PREFIX = 6'd2;
  localparam logic [LEN_W-1:0] LEN_FA     = 6'd3;
  localparam logic [LEN_W-1:0] LEN_MD     = 6'd3;
  localparam logic [LEN_W-1:0] LEN_AC     = 6'd4;
  localparam logic [LEN_W-1:0] LEN_SM     = 6'd5;
  localparam logic [LEN_W-1:0] LEN_IF     = 6'd37;

  localparam logic [7:0] MODE_NONE = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [4:0] METER_FULL = 5'd30;
  localparam int METER_LIMIT_BIT = 31;

  typedef enum logic [1:0] {
    KIND_FREQ  = 2'd0,
    KIND_MODE  = 2'd1,
    KIND_METER = 2'd2,
    KIND_TUNER = 2'd3
  } kind_t;

  // Everything about the current response except its decimal accumulator.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [15:0]      prefix;
    logic [7:0]       third;
    logic [7:0]       fourth;
    logic [7:0]       prev;
    logic             bad_win;
    logic             tail;
  } line_t;

  typedef struct packed {
    kind_t              kind;
    logic [FREQ_W-1:0]  freq;
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] level;
    logic               tuner;
  } evt_t;

  typedef struct packed {
    logic hit;
    logic save_freq;
    logic save_mode;
    evt_t evt;
  } dec_t;

  // Bits needed to hold any value of the given number of decimal digits.
  function automatic int acc_width(input int digits);
    return (digits * 3322 + 999) / 1000;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// File: hdl/crp_byte_if.sv
// ---------------------------------------------------------------------------
// crp_byte_if: receive character channel
// Valid/ready channel carrying one received character per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/crp_event_if.sv
// ---------------------------------------------------------------------------
// crp_event_if: decoded event channel
// Valid/ready channel carrying one decoded rig event per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crp_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [36:0] frequency_hz;
  logic [3:0]  mode_code;
  logic [7:0]  signal_level;
  logic        tuner_on;

  modport source (output valid, output event_kind, output frequency_hz,
                  output mode_code, output signal_level, output tuner_on,
                  input ready);
  modport sink (input valid, input event_kind, input frequency_hz,
                input mode_code, input signal_level, input tuner_on,
                output ready);
endinterface

`default_nettype wire

// File: hdl/crp_decode.sv
// ---------------------------------------------------------------------------
// crp_decode: response decoder
// Classifies a finished response by prefix and forms at most one event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crp_decode
  import crp_pkg::*;
#(
  parameter int FREQ_DIGITS = FREQ_DIGITS_DEF
) (
  input  line_t                             line,
  input  logic [acc_width(FREQ_DIGITS)-1:0] value,
  input  logic [FREQ_W-1:0]                 saved_freq,
  input  logic [7:0]                        saved_mode,
  output dec_t                              dec
);

  localparam int ACC_W = acc_width(FREQ_DIGITS);

  logic              clean;
  logic [FREQ_W-1:0] freq;
  logic              freq_new;
  logic [3:0]        mode;
  logic              meter_ok;
  logic [4:0]        meter_raw;
  logic [8:0]        meter_x17;
  logic [7:0]        third_off;

  always_comb begin
    clean     = !line.bad_win && !line.tail;
    freq      = FREQ_W'(value);
    freq_new  = (freq != '0) && (freq != saved_freq);
    third_off = line.third - CH_ZERO;
    mode      = third_off[3:0];
    meter_ok  = ((value >> METER_LIMIT_BIT) == '0);
    meter_raw = value[4:0];
    // raw * 255 / 30 equals raw * 17 / 2 for every raw below 30
    meter_x17 = {meter_raw, 4'b0000} + 9'(meter_raw);

    dec           = '0;
    dec.evt.kind  = KIND_FREQ;

    // drop short responses and error replies
    if (line.length >= LEN_PREFIX && line.prev != CH_QUERY) begin
      case (line.prefix)
        PFX_FA: begin
          if (line.length >= LEN_FA && clean && freq_new) begin
            dec.hit       = 1'b1;
            dec.save_freq = 1'b1;
            dec.evt.freq  = freq;
          end
        end
        PFX_MD: begin
          if (line.length >= LEN_MD && is_digit(line.third) &&
              {4'b0000, mode} != saved_mode) begin
            dec.hit       = 1'b1;
            dec.save_mode = 1'b1;
            dec.evt.kind  = KIND_MODE;
            dec.evt.mode  = mode;
          end
        end
        PFX_SM: begin
          if (line.length >= LEN_SM && clean && meter_ok) begin
            dec.hit      = 1'b1;
            dec.evt.kind = KIND_METER;
            if (value >= ACC_W'(METER_FULL)) begin
              dec.evt.level = LEVEL_FULL;
            end else begin
              dec.evt.level = meter_x17[8:1];
            end
          end
        end
        PFX_IF: begin
          if (line.length >= LEN_IF && !line.bad_win && freq_new) begin
            dec.hit       = 1'b1;
            dec.save_freq = 1'b1;
            dec.evt.freq  = freq;
          end
        end
        PFX_AC: begin
          if (line.length >= LEN_AC) begin
            dec.hit       = 1'b1;
            dec.evt.kind  = KIND_TUNER;
            dec.evt.tuner = (line.fourth == CH_ONE);
          end
        end
        default: begin
          dec.hit = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/cat_response_parser.sv
// ---------------------------------------------------------------------------
// cat_response_parser: ASCII rig-control response parser
// Splits the receive stream at ';' and reports frequency, mode, meter and
// tuner events decoded from each finished response.
// ---------------------------------------------------------------------------
// Pipeline: the ';' that ends a response waits in the character register; its
//   event is decoded from there and held in the event output register.
// Throughput: one character per cycle; the only limit is the event output
//   register, which stalls the character register while it is held.
// Reset (rst, synchronous): clears the line state, the saved frequency
//   to 0, the saved mode to 255, and drops both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module cat_response_parser
  import crp_pkg::*;
#(
  parameter int FREQ_DIGITS = FREQ_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  crp_byte_if.sink           rx,
  crp_event_if.source        events
);

  localparam int ACC_W = acc_width(FREQ_DIGITS);
  // first length at which a character falls past the digit window
  localparam logic [LEN_W-1:0] WIN_END = LEN_W'(2 + FREQ_DIGITS);

  // character register
  logic       byte_valid;
  logic [7:0] byte_q;

  // per-line state
  line_t            line;
  line_t            line_next;
  logic [ACC_W-1:0] value;
  logic [ACC_W-1:0] value_next;

  // state kept across responses
  logic [FREQ_W-1:0] saved_freq;
  logic [7:0]        saved_mode;

  // event output register
  logic out_valid;
  evt_t out_evt;

  logic       advance;
  logic       step;
  logic       term;
  logic       in_win;
  logic [7:0] digit_off;
  dec_t       dec;

  // The output register frees when it is empty or being taken; the character
  // register advances with it; new characters enter every cycle it is free.
  assign advance  = !out_valid || events.ready;
  assign step     = byte_valid && advance;
  assign term     = (byte_q == CH_TERM);
  assign rx.ready = !byte_valid || advance;

  crp_decode #(
    .FREQ_DIGITS(FREQ_DIGITS)
  ) u_decode (
    .line       (line),
    .value      (value),
    .saved_freq (saved_freq),
    .saved_mode (saved_mode),
    .dec        (dec)
  );

  // Line bookkeeping for a non-terminator character: capture the first four
  // characters, accumulate the digit window, flag anything past it.
  always_comb begin
    line_next  = line;
    value_next = value;
    in_win     = (line.length >= LEN_PREFIX) && (line.length < WIN_END);
    digit_off  = byte_q - CH_ZERO;

    case (line.length)
      6'd0:    line_next.prefix = {byte_q, 8'h00};
      6'd1:    line_next.prefix = {line.prefix[15:8], byte_q};
      6'd2:    line_next.third  = byte_q;
      6'd3:    line_next.fourth = byte_q;
      default: line_next.prefix = line.prefix;
    endcase

    if (in_win) begin
      if (is_digit(byte_q)) begin
        // times ten as two shifts and an add
        value_next = (value << 3) + (value << 1) + ACC_W'(digit_off[3:0]);
      end else begin
        line_next.bad_win = 1'b1;
      end
    end else if (line.length >= WIN_END) begin
      line_next.tail = 1'b1;
    end

    line_next.prev = byte_q;
    if (line.length != LEN_MAX) begin
      line_next.length = line.length + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      out_valid  <= 1'b0;
      line       <= '0;
      value      <= '0;
      saved_freq <= '0;
      saved_mode <= MODE_NONE;
    end else begin
      // hold the character while the output is stalled
      if (rx.ready) begin
        byte_valid <= rx.valid;
      end

      if (advance) begin
        out_valid <= step && term && dec.hit;
      end

      if (step) begin
        if (term) begin
          // decode and start a fresh line
          line  <= '0;
          value <= '0;
          if (dec.save_freq) begin
            saved_freq <= dec.evt.freq;
          end
          if (dec.save_mode) begin
            saved_mode <= {4'b0000, dec.evt.mode};
          end
        end else begin
          line  <= line_next;
          value <= value_next;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_q <= rx.rx_byte;
    end
    if (step && term && dec.hit) begin
      out_evt <= dec.evt;
    end
  end

  assign events.valid        = out_valid;
  assign events.event_kind   = out_evt.kind;
  assign events.frequency_hz = out_evt.freq;
  assign events.mode_code    = out_evt.mode;
  assign events.signal_level = out_evt.level;
  assign events.tuner_on     = out_evt.tuner;

  // A frequency event never carries zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_evt.kind == KIND_FREQ) |-> (out_evt.freq != '0))
    else $error("frequency event with zero frequency");

  // A mode event carries a decimal digit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_evt.kind == KIND_MODE) |->
      (out_evt.mode <= 4'd9))
    else $error("mode event outside 0..9");

  // The line state is empty right after a terminator is consumed.
  assert property (@(posedge clk) disable iff (rst)
    (step && term) |=> (line.length == '0 && value == '0))
    else $error("line state not cleared after terminator");

  // A new event only follows a consumed terminator.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && term))
    else $error("event raised without a terminator");

  // A stalled output blocks the character register when it is full.
  assert property (@(posedge clk) disable iff (rst)
    (byte_valid && out_valid && !events.ready) |-> !rx.ready)
    else $error("character accepted over a stalled event");

endmodule

`default_nettype wire

// File: bench/tb_cat_response_parser.sv
// ---------------------------------------------------------------------------
// tb_cat_response_parser: self-checking bench for the CAT response parser
// Feeds whole responses one character per transaction. A directed table comes
// first, followed by random well-formed, damaged and noise responses. Every
// accepted character goes through a bench-side parser that queues the
// expected event, and each event leaving the block is compared field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cat_response_parser;
  import crp_pkg::*;

  localparam int FREQ_DIGITS  = FREQ_DIGITS_DEF;
  localparam int RANDOM_CHARS = 1080;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic [63:0] METER_RAW_MAX = 64'd2147483647;
  localparam evt_t NO_EVT = '0;

  // How a directed row is checked: by the bench parser, or against a value
  // typed into the table (no event, or one given event).
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_EVENT
  } row_kind_t;

  logic clk = 1'b0;
  logic rst;

  crp_byte_if  rx_ch ();
  crp_event_if evt_ch ();

  cat_response_parser #(
    .FREQ_DIGITS(FREQ_DIGITS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .events (evt_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Bench-side parser state: the line being collected and the saved values
  // that decide whether a frequency or mode is reported again.
  // -------------------------------------------------------------------------
  line_t             cur_line;
  logic [63:0]       cur_digits;
  logic [FREQ_W-1:0] held_freq;
  logic [7:0]        held_mode;

  evt_t pending_events [$];

  // Directed table and the response currently being sent.
  string      row_text [$];
  row_kind_t  row_kind [$];
  evt_t       row_evt [$];
  logic [7:0] msg_bytes [$];
  logic [7:0] last_fa [$];

  int   errors = 0;
  int   chars_sent = 0;
  int   lines_sent = 0;
  int   kind_seen [4] = '{0, 0, 0, 0};
  int   burst_left = 0;
  bit   gapless = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   holds_done = 0;
  int   cycle_count = 0;
  logic [31:0] rcv_cycle = '0;

  function automatic void reset_parser();
    cur_line   = '0;
    cur_digits = '0;
    held_freq  = '0;
    held_mode  = MODE_NONE;
  endfunction

  // Advance the parser by one character; on ';' decode the finished line.
  function automatic void parse_char(input logic [7:0] c, output logic hit,
                                     output evt_t ev);
    int                pos;
    logic              clean;
    logic              ok;
    logic [FREQ_W-1:0] f;
    logic [7:0]        m;
    logic [63:0]       lvl;
    pos = int'(cur_line.length);
    hit = 1'b0;
    ev  = NO_EVT;
    if (c == CH_TERM) begin
      clean = !cur_line.bad_win && !cur_line.tail;
      f = cur_digits[FREQ_W-1:0];
      m = cur_line.third - CH_ZERO;
      // A line ending in '?' is an error reply: drop it whatever its prefix.
      ok = (cur_line.length >= LEN_PREFIX) && (cur_line.prev != CH_QUERY);
      if (ok) begin
        case (cur_line.prefix)
          PFX_FA: begin
            if (cur_line.length >= LEN_FA && clean && f != 0 && f != held_freq) begin
              held_freq = f;
              hit = 1'b1;
              ev.kind = KIND_FREQ;
              ev.freq = f;
            end
          end
          PFX_MD: begin
            if (cur_line.length >= LEN_MD && cur_line.third >= CH_ZERO &&
                cur_line.third <= CH_NINE && m != held_mode) begin
              held_mode = m;
              hit = 1'b1;
              ev.kind = KIND_MODE;
              ev.mode = m[MODE_W-1:0];
            end
          end
          PFX_SM: begin
            if (cur_line.length >= LEN_SM && clean && cur_digits <= METER_RAW_MAX) begin
              lvl = (cur_digits >= 30) ? 64'd255 : cur_digits * 255 / 30;
              hit = 1'b1;
              ev.kind = KIND_METER;
              ev.level = lvl[LEVEL_W-1:0];
            end
          end
          PFX_IF: begin
            // Only the frequency window is checked; the rest of the line is free.
            if (cur_line.length >= LEN_IF && !cur_line.bad_win && f != 0 &&
                f != held_freq) begin
              held_freq = f;
              hit = 1'b1;
              ev.kind = KIND_FREQ;
              ev.freq = f;
            end
          end
          PFX_AC: begin
            if (cur_line.length >= LEN_AC) begin
              hit = 1'b1;
              ev.kind = KIND_TUNER;
              ev.tuner = (cur_line.fourth == CH_ONE);
            end
          end
          default: ;
        endcase
      end
      cur_line   = '0;
      cur_digits = '0;
    end else begin
      case (pos)
        0: cur_line.prefix = {c, 8'h00};
        1: cur_line.prefix[7:0] = c;
        2: cur_line.third = c;
        3: cur_line.fourth = c;
        default: ;
      endcase
      // Accumulate the digit window; anything past it only marks a tail.
      if (pos >= 2 && pos < 2 + FREQ_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE)
          cur_digits = cur_digits * 10 + 64'(c - CH_ZERO);
        else
          cur_line.bad_win = 1'b1;
      end else if (pos >= 2 + FREQ_DIGITS) begin
        cur_line.tail = 1'b1;
      end
      cur_line.prev = c;
      if (cur_line.length != LEN_MAX)
        cur_line.length = cur_line.length + 1'b1;
    end
  endfunction

  function automatic evt_t mk_evt(kind_t k, logic [FREQ_W-1:0] f,
                                  logic [MODE_W-1:0] m, logic [LEVEL_W-1:0] l,
                                  logic t);
    evt_t e;
    e.kind  = k;
    e.freq  = f;
    e.mode  = m;
    e.level = l;
    e.tuner = t;
    return e;
  endfunction

  function automatic void add_row(string s, row_kind_t k, evt_t e);
    row_text.push_back(s);
    row_kind.push_back(k);
    row_evt.push_back(e);
  endfunction

  // -------------------------------------------------------------------------
  // Response builders: append characters to msg_bytes.
  // -------------------------------------------------------------------------
  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++)
      msg_bytes.push_back(s[i]);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) msg_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void put_value(longint unsigned v, int n);
    logic [7:0] d [$];
    repeat (n) begin
      d.push_front(8'(CH_ZERO + v % 10));
      v = v / 10;
    end
    foreach (d[i]) msg_bytes.push_back(d[i]);
  endfunction

  function automatic void put_last_freq();
    foreach (last_fa[i]) msg_bytes.push_back(last_fa[i]);
  endfunction

  // Any character except the terminator.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == CH_TERM) ? 8'h2B : c;
  endfunction

  function automatic void put_junk(int n);
    repeat (n) msg_bytes.push_back(junk_char());
  endfunction

  // Signs and whitespace mostly, otherwise any non-terminator.
  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 3))
      0: return 8'h2B;
      1: return 8'h2D;
      2: return 8'h20;
      default: return junk_char();
    endcase
  endfunction

  function automatic void corrupt_one();
    if (msg_bytes.size() > 2)
      msg_bytes[$urandom_range(2, msg_bytes.size() - 1)] = bad_char();
  endfunction

  // Build one random response, mostly well formed with random content.
  function automatic void gen_line();
    int pick;
    int r;
    msg_bytes.delete();
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 9);
    if (pick < 20) begin
      put_str("FA");
      if (r < 5 || (r < 7 && last_fa.size() == 0)) begin
        last_fa.delete();
        repeat (FREQ_DIGITS) last_fa.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        put_last_freq();
      end else if (r < 7) begin
        put_last_freq();
      end else if (r == 7) begin
        put_digits($urandom_range(1, FREQ_DIGITS + 2));
      end else if (r == 8) begin
        put_value(0, FREQ_DIGITS);
      end else begin
        put_digits(FREQ_DIGITS);
        corrupt_one();
      end
      if ($urandom_range(0, 19) == 0)
        msg_bytes.push_back(CH_QUERY);
    end else if (pick < 35) begin
      put_str("MD");
      if (r < 7) begin
        put_digits(1);
      end else if (r == 7) begin
        msg_bytes.push_back(bad_char());
      end else if (r == 8) begin
        put_digits($urandom_range(2, 4));
      end else begin
        put_digits(1);
        msg_bytes.push_back(CH_QUERY);
      end
    end else if (pick < 55) begin
      put_str("SM");
      if (r < 6) begin
        put_value($urandom_range(0, 40), $urandom_range(3, 4));
      end else if (r < 8) begin
        put_digits($urandom_range(3, FREQ_DIGITS + 1));
      end else if (r == 8) begin
        put_digits($urandom_range(0, 2));
      end else begin
        put_value($urandom_range(0, 40), 4);
        corrupt_one();
      end
    end else if (pick < 65) begin
      put_str("IF");
      if (r < 3 && last_fa.size() == FREQ_DIGITS)
        put_last_freq();
      else
        put_digits(FREQ_DIGITS);
      if (r == 9)
        corrupt_one();
      // Straddle the minimum length, and now and then overrun the counter.
      if ($urandom_range(0, 9) == 0)
        put_junk($urandom_range(50, 60));
      else
        put_junk($urandom_range(21, 28));
    end else if (pick < 80) begin
      put_str("AC");
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 4))
          0, 1: msg_bytes.push_back(CH_ZERO);
          2, 3: msg_bytes.push_back(CH_ONE);
          default: msg_bytes.push_back(junk_char());
        endcase
      end
    end else if (pick < 90) begin
      put_junk($urandom_range(0, 3));
    end else begin
      // Raw noise: may contain terminators of its own and overrun the length.
      repeat ($urandom_range(1, 70)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
    msg_bytes.push_back(CH_TERM);
  endfunction

  // -------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps, and gapless stretches.
  // -------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, output logic hit, output evt_t ev);
    if (burst_left == 0) begin
      if (!gapless) begin
        rx_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= c;
    do @(posedge clk); while (!rx_ch.ready);
    // The character is accepted at this edge: advance the parser now.
    burst_left--;
    chars_sent++;
    parse_char(c, hit, ev);
  endtask

  // Send msg_bytes; a typed row replaces the parser's verdict on its ';'.
  task automatic send_line(row_kind_t k, evt_t typed_evt);
    logic hit;
    evt_t ev;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_char(msg_bytes[i], hit, ev);
      if (k != ROW_PREDICT && i == msg_bytes.size() - 1) begin
        if (k == ROW_EVENT)
          pending_events.push_back(typed_evt);
      end else if (hit) begin
        pending_events.push_back(ev);
      end
    end
    lines_sent++;
  endtask

  // Drop valid and hold until every queued event has come out.
  task automatic drain_events();
    rx_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // -------------------------------------------------------------------------
  // Receiver: cycles through four stall patterns picked by rcv_cycle[9:8], and on
  // request holds ready low for a long stretch so the block backs up.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      evt_ch.ready <= 1'b0;
    end else begin
      case (rcv_cycle[9:8])
        2'd0: evt_ch.ready <= 1'b1;
        2'd1: evt_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: evt_ch.ready <= (rcv_cycle[2:0] == 3'd0);
        default: evt_ch.ready <= (rcv_cycle[3:2] != 2'b11);
      endcase
    end
    rcv_cycle = rcv_cycle + 1;
  end

  // -------------------------------------------------------------------------
  // Event checker: compare each accepted event with the oldest expectation.
  // -------------------------------------------------------------------------
  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    evt_t want;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual kind %0d freq %0d",
                 $time, evt_ch.event_kind, evt_ch.frequency_hz);
        errors++;
      end else begin
        want = pending_events.pop_front();
        cmp_field("event_kind", 64'(want.kind), 64'(evt_ch.event_kind));
        cmp_field("frequency_hz", 64'(want.freq), 64'(evt_ch.frequency_hz));
        cmp_field("mode_code", 64'(want.mode), 64'(evt_ch.mode_code));
        cmp_field("signal_level", 64'(want.level), 64'(evt_ch.signal_level));
        cmp_field("tuner_on", 64'(want.tuner), 64'(evt_ch.tuner_on));
        kind_seen[evt_ch.event_kind]++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
      $display("tb_cat_response_parser failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Directed table: expected value typed in where it is obvious, otherwise
  // left to the bench parser. Row order matters: saved values carry over.
  // -------------------------------------------------------------------------
  function automatic void build_table();
    add_row("MD1;", ROW_EVENT, mk_evt(KIND_MODE, 0, 1, 0, 0));
    add_row("MD1;", ROW_QUIET, NO_EVT);                 // mode unchanged
    add_row("MD2?;", ROW_QUIET, NO_EVT);                // error reply
    add_row("MD9;", ROW_EVENT, mk_evt(KIND_MODE, 0, 9, 0, 0));
    add_row("MDA;", ROW_QUIET, NO_EVT);
    add_row("FA00014074000;", ROW_EVENT, mk_evt(KIND_FREQ, 37'd14074000, 0, 0, 0));
    add_row("FA00014074000;", ROW_QUIET, NO_EVT);       // frequency unchanged
    add_row("FA99999999999;", ROW_EVENT, mk_evt(KIND_FREQ, 37'd99999999999, 0, 0, 0));
    add_row("FA00000000000;", ROW_QUIET, NO_EVT);       // zero never reported
    add_row("FA000000000001;", ROW_QUIET, NO_EVT);      // one digit too many
    add_row("FA+0007000000;", ROW_QUIET, NO_EVT);       // sign
    add_row("FA 7000000;", ROW_QUIET, NO_EVT);          // whitespace
    add_row("FA;", ROW_QUIET, NO_EVT);                  // no digits
    add_row("FA7;", ROW_PREDICT, NO_EVT);
    add_row("SM0000;", ROW_EVENT, mk_evt(KIND_METER, 0, 0, 0, 0));
    add_row("SM0015;", ROW_PREDICT, NO_EVT);
    add_row("SM0030;", ROW_EVENT, mk_evt(KIND_METER, 0, 0, LEVEL_FULL, 0));
    add_row("SM2147483647;", ROW_EVENT, mk_evt(KIND_METER, 0, 0, LEVEL_FULL, 0));
    add_row("SM2147483648;", ROW_QUIET, NO_EVT);        // raw value too large
    add_row("SM00;", ROW_QUIET, NO_EVT);                // too short
    add_row("AC011;", ROW_EVENT, mk_evt(KIND_TUNER, 0, 0, 0, 1));
    add_row("AC000;", ROW_EVENT, mk_evt(KIND_TUNER, 0, 0, 0, 0));
    add_row("AC1;", ROW_QUIET, NO_EVT);
    add_row("IF00007074000     +000000000020000000;", ROW_EVENT,
            mk_evt(KIND_FREQ, 37'd7074000, 0, 0, 0));
    add_row("IF00003573000    +000000000020000000;", ROW_PREDICT, NO_EVT);
    add_row("XY123;", ROW_QUIET, NO_EVT);
    add_row(";", ROW_QUIET, NO_EVT);
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence.
  // -------------------------------------------------------------------------
  initial begin
    int dir_chars;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    evt_ch.ready = 1'b0;
    reset_parser();
    build_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (int r = 0; r < row_text.size(); r++) begin
      msg_bytes.delete();
      put_str(row_text[r]);
      send_line(row_kind[r], row_evt[r]);
    end
    drain_events();
    dir_chars = chars_sent;

    // Random responses; alternate gapped and gapless stretches.
    while (chars_sent < dir_chars + RANDOM_CHARS) begin
      gapless = ((lines_sent / 12) % 3) == 0;
      // Long receiver hold-off while the sender keeps offering characters.
      if (lines_sent == row_text.size() + 20)
        hold_req = 1'b1;
      // Sender pause until every expected event has come out.
      if (lines_sent == row_text.size() + 50)
        drain_events();
      gen_line();
      send_line(ROW_PREDICT, NO_EVT);
    end

    drain_events();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d characters in %0d responses (%0d directed rows), %0d long hold-offs",
             chars_sent, lines_sent, row_text.size(), holds_done);
    $display("Checked events: %0d frequency, %0d mode, %0d meter, %0d tuner",
             kind_seen[KIND_FREQ], kind_seen[KIND_MODE], kind_seen[KIND_METER],
             kind_seen[KIND_TUNER]);
    if (errors == 0 && pending_events.size() == 0)
      $display("tb_cat_response_parser passed");
    else
      $display("tb_cat_response_parser failed");
    $finish;
  end

endmodule

// File: cat_response_parser.f
hdl/crp_pkg.sv
hdl/crp_byte_if.sv
hdl/crp_event_if.sv
hdl/crp_decode.sv
hdl/cat_response_parser.sv
bench/tb_cat_response_parser.sv
